[sv/tds_pkg.sv]
// Shared types, constants and request codes for the task dependency scheduler.
package tds_pkg;

	// Table size and derived widths
	localparam int MAX_TASKS   = 16;
	localparam int ID_W        = $clog2(MAX_TASKS);
	localparam int CNT_W       = $clog2(MAX_TASKS + 1);
	localparam int REQ_W       = 3;
	localparam int QUEUE_DEPTH = 4;

	// Request codes as they arrive on req_type
	localparam logic [REQ_W-1:0] REQ_ADD   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_EDGE  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_CHECK = 3'd2;
	localparam logic [REQ_W-1:0] REQ_START = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DONE  = 3'd4;

	// Classified operation carried through the request queue
	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_EDGE  = 3'd1,
		OP_CHECK = 3'd2,
		OP_START = 3'd3,
		OP_DONE  = 3'd4,
		OP_BAD   = 3'd5
	} op_t;

	// One queued request
	typedef struct packed {
		op_t             op;
		logic            present;
		logic [ID_W-1:0] from_id;
		logic [ID_W-1:0] to_id;
		logic [ID_W-1:0] fin_id;
	} req_item_t;

	// One result item
	typedef struct packed {
		logic             kind;
		logic [ID_W-1:0]  dispatch_task;
		logic             ok;
		logic [ID_W-1:0]  assigned_id;
		logic             graph_done;
		logic             is_running;
		logic             is_finished;
		logic [CNT_W-1:0] done_total;
		logic [CNT_W-1:0] task_total;
		logic             last;
	} res_t;

endpackage

[sv/tds_front.sv]
// Front end: accepts request items, classifies them and queues them for the back end.
module tds_front #(
	parameter int QUEUE_DEPTH = tds_pkg::QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [tds_pkg::REQ_W-1:0] req_type,
	input  logic                      task_present,
	input  logic [tds_pkg::ID_W-1:0]  from_task,
	input  logic [tds_pkg::ID_W-1:0]  to_task,
	input  logic [tds_pkg::ID_W-1:0]  finished_task,
	output tds_pkg::req_item_t        q_item,
	output logic                      q_valid,
	input  logic                      q_pop
);
	import tds_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QW = $clog2(QUEUE_DEPTH + 1);

	req_item_t       fifo_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QW-1:0]   count_q;
	req_item_t       cls;
	logic            push;

	// Classify the request code
	always_comb begin
		cls.present = task_present;
		cls.from_id = from_task;
		cls.to_id   = to_task;
		cls.fin_id  = finished_task;
		case (req_type)
			REQ_ADD:   cls.op = OP_ADD;
			REQ_EDGE:  cls.op = OP_EDGE;
			REQ_CHECK: cls.op = OP_CHECK;
			REQ_START: cls.op = OP_START;
			REQ_DONE:  cls.op = OP_DONE;
			default:   cls.op = OP_BAD;
		endcase
	end

	assign in_ready = (count_q != QW'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign q_item   = fifo_q[rd_ptr_q];

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !q_pop) begin
				count_q <= count_q + QW'(1);
			end else if (q_pop && !push) begin
				count_q <= count_q - QW'(1);
			end
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

endmodule

[sv/tds_back.sv]
// Back end: sequencer that holds the task graph, runs checks and releases dependents.
module tds_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tds_pkg::req_item_t q_item,
	input  logic               q_valid,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output tds_pkg::res_t      res
);
	import tds_pkg::*;

	localparam int MT = MAX_TASKS;
	localparam int IW = ID_W;
	localparam int CW = CNT_W;
	localparam int AW = 2 * IW;

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_DECODE  = 13'b0000000000010,
		S_SINK    = 13'b0000000000100,
		S_SEED    = 13'b0000000001000,
		S_WPOP    = 13'b0000000010000,
		S_WREQ    = 13'b0000000100000,
		S_WUPD    = 13'b0000001000000,
		S_VERDICT = 13'b0000010000000,
		S_LAUNCH  = 13'b0000100000000,
		S_DREQ    = 13'b0001000000000,
		S_DUPD    = 13'b0010000000000,
		S_DEND    = 13'b0100000000000,
		S_STATUS  = 13'b1000000000000
	} state_t;

	// Control state
	state_t          state_q, state_n;
	logic [CW-1:0]   tc_q, tc_n;
	logic            running_q, running_n, finished_q, finished_n;
	logic [CW-1:0]   remaining_q, remaining_n, done_cnt_q, done_cnt_n;
	logic [MT-1:0]   sched_q, sched_n, done_q, done_n;
	logic            out_valid_q;

	// Work registers
	req_item_t       cur_q, cur_n;
	logic [CW-1:0]   i_q, i_n, head_q, head_n, tail_q, tail_n, visited_q, visited_n;
	logic [CW-1:0]   len_cur_q, len_cur_n;
	logic [1:0]      sinks_q, sinks_n;
	logic [IW-1:0]   wid_q, wid_n;
	logic            st_ok_q, st_ok_n, st_gd_q, st_gd_n;
	logic [IW-1:0]   st_id_q, st_id_n;
	res_t            res_q;

	// Per-task tables
	logic [CW-1:0]   len_q  [MT];
	logic [MT-1:0]   eb_q   [MT];
	logic [CW-1:0]   pre_q  [MT];
	logic [CW-1:0]   pend_q [MT];
	logic [CW-1:0]   scr_q  [MT];
	logic [IW-1:0]   wq_q   [MT];
	logic [IW-1:0]   dep_mem [MT*MT];
	logic [IW-1:0]   dm_rdata_q;

	// Table write strobes
	logic            len_we, eb_we, pre_we, pend_we, scr_we, wq_we, dm_we, dm_re;
	logic [IW-1:0]   len_wa, eb_wa, pre_wa, pend_wa, scr_wa, wq_wa;
	logic [CW-1:0]   len_wd, pre_wd, pend_wd, scr_wd;
	logic [MT-1:0]   eb_wd;
	logic [IW-1:0]   wq_wd, dm_wd;
	logic [AW-1:0]   dm_wa, dm_ra;

	// Result emission
	logic            em_v;
	res_t            em_res;
	logic            out_free;

	// Helpers
	logic [IW-1:0]   idx, d;
	logic [1:0]      sinks_step;
	logic [CW-1:0]   np, ns;
	logic            fire;

	assign out_free  = !out_valid_q || out_ready;
	assign idx       = i_q[IW-1:0];
	assign d         = dm_rdata_q;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	// Sequencer
	always_comb begin
		state_n     = state_q;
		tc_n        = tc_q;
		running_n   = running_q;
		finished_n  = finished_q;
		remaining_n = remaining_q;
		done_cnt_n  = done_cnt_q;
		sched_n     = sched_q;
		done_n      = done_q;
		cur_n       = cur_q;
		i_n         = i_q;
		head_n      = head_q;
		tail_n      = tail_q;
		visited_n   = visited_q;
		len_cur_n   = len_cur_q;
		sinks_n     = sinks_q;
		wid_n       = wid_q;
		st_ok_n     = st_ok_q;
		st_gd_n     = st_gd_q;
		st_id_n     = st_id_q;
		q_pop       = 1'b0;
		len_we = 1'b0; len_wa = '0; len_wd = '0;
		eb_we  = 1'b0; eb_wa  = '0; eb_wd  = '0;
		pre_we = 1'b0; pre_wa = '0; pre_wd = '0;
		pend_we = 1'b0; pend_wa = '0; pend_wd = '0;
		scr_we = 1'b0; scr_wa = '0; scr_wd = '0;
		wq_we  = 1'b0; wq_wa  = '0; wq_wd  = '0;
		dm_we  = 1'b0; dm_wa  = '0; dm_wd  = '0;
		dm_re  = 1'b0; dm_ra  = '0;
		em_v   = 1'b0;
		em_res = '0;
		sinks_step = sinks_q;
		np     = '0;
		ns     = '0;
		fire   = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					cur_n   = q_item;
					state_n = S_DECODE;
				end
			end

			S_DECODE: begin
				st_ok_n = 1'b0;
				st_id_n = '0;
				st_gd_n = 1'b0;
				state_n = S_STATUS;
				case (cur_q.op)
					OP_ADD: begin
						if (cur_q.present && !running_q && tc_q < CW'(MT)) begin
							len_we = 1'b1; len_wa = tc_q[IW-1:0]; len_wd = '0;
							eb_we  = 1'b1; eb_wa  = tc_q[IW-1:0]; eb_wd  = '0;
							pre_we = 1'b1; pre_wa = tc_q[IW-1:0]; pre_wd = '0;
							pend_we = 1'b1; pend_wa = tc_q[IW-1:0]; pend_wd = '0;
							tc_n    = tc_q + CW'(1);
							st_ok_n = 1'b1;
							st_id_n = tc_q[IW-1:0];
						end
					end
					OP_EDGE: begin
						if (!running_q && CW'(cur_q.from_id) < tc_q && CW'(cur_q.to_id) < tc_q
						    && cur_q.from_id != cur_q.to_id) begin
							st_ok_n = 1'b1;
							if (!eb_q[cur_q.from_id][cur_q.to_id]
							    && len_q[cur_q.from_id] < CW'(MT)) begin
								dm_we  = 1'b1;
								dm_wa  = {cur_q.from_id, len_q[cur_q.from_id][IW-1:0]};
								dm_wd  = cur_q.to_id;
								len_we = 1'b1;
								len_wa = cur_q.from_id;
								len_wd = len_q[cur_q.from_id] + CW'(1);
								eb_we  = 1'b1;
								eb_wa  = cur_q.from_id;
								eb_wd  = eb_q[cur_q.from_id] | (MT'(1) << cur_q.to_id);
								pre_we = 1'b1;
								pre_wa = cur_q.to_id;
								pre_wd = pre_q[cur_q.to_id] + CW'(1);
							end
						end
					end
					OP_CHECK, OP_START: begin
						if (!(cur_q.op == OP_START && running_q) && tc_q != '0) begin
							i_n     = '0;
							sinks_n = '0;
							state_n = S_SINK;
						end
					end
					OP_DONE: begin
						if (running_q && CW'(cur_q.fin_id) < tc_q && !done_q[cur_q.fin_id]) begin
							done_n[cur_q.fin_id] = 1'b1;
							done_cnt_n  = done_cnt_q + CW'(1);
							remaining_n = (remaining_q != '0) ? remaining_q - CW'(1) : remaining_q;
							len_cur_n   = len_q[cur_q.fin_id];
							i_n         = '0;
							st_ok_n     = 1'b1;
							state_n     = S_DREQ;
						end
					end
					default: begin
						state_n = S_STATUS;
					end
				endcase
			end

			// Count sinks and load the in-degree scratch copy
			S_SINK: begin
				if (len_q[idx] == '0 && sinks_q != 2'd2) begin
					sinks_step = sinks_q + 2'd1;
				end
				sinks_n = sinks_step;
				scr_we  = 1'b1; scr_wa = idx; scr_wd = pre_q[idx];
				if (i_q == tc_q - CW'(1)) begin
					if (sinks_step != 2'd1) begin
						st_ok_n = 1'b0;
						state_n = S_STATUS;
					end else begin
						i_n     = '0;
						tail_n  = '0;
						state_n = S_SEED;
					end
				end else begin
					i_n = i_q + CW'(1);
				end
			end

			// Seed the walk queue with tasks that have no prerequisites
			S_SEED: begin
				if (scr_q[idx] == '0) begin
					wq_we  = 1'b1; wq_wa = tail_q[IW-1:0]; wq_wd = idx;
					tail_n = tail_q + CW'(1);
				end
				if (i_q == tc_q - CW'(1)) begin
					head_n    = '0;
					visited_n = '0;
					state_n   = S_WPOP;
				end else begin
					i_n = i_q + CW'(1);
				end
			end

			S_WPOP: begin
				if (head_q < tail_q) begin
					wid_n     = wq_q[head_q[IW-1:0]];
					len_cur_n = len_q[wq_q[head_q[IW-1:0]]];
					head_n    = head_q + CW'(1);
					visited_n = visited_q + CW'(1);
					i_n       = '0;
					state_n   = S_WREQ;
				end else begin
					state_n = S_VERDICT;
				end
			end

			S_WREQ: begin
				if (i_q < len_cur_q) begin
					dm_re   = 1'b1;
					dm_ra   = {wid_q, idx};
					state_n = S_WUPD;
				end else begin
					state_n = S_WPOP;
				end
			end

			S_WUPD: begin
				i_n     = i_q + CW'(1);
				state_n = S_WREQ;
				if (CW'(d) < tc_q && scr_q[d] != '0) begin
					ns     = scr_q[d] - CW'(1);
					scr_we = 1'b1; scr_wa = d; scr_wd = ns;
					if (ns == '0 && tail_q < CW'(MT)) begin
						wq_we  = 1'b1; wq_wa = tail_q[IW-1:0]; wq_wd = d;
						tail_n = tail_q + CW'(1);
					end
				end
			end

			S_VERDICT: begin
				st_ok_n = (visited_q == tc_q);
				state_n = S_STATUS;
				if (cur_q.op == OP_START && visited_q == tc_q) begin
					running_n   = 1'b1;
					finished_n  = 1'b0;
					remaining_n = tc_q;
					done_cnt_n  = '0;
					i_n         = '0;
					state_n     = S_LAUNCH;
				end
			end

			// Load pending counts and dispatch root tasks in id order
			S_LAUNCH: begin
				fire = (pre_q[idx] == '0);
				if (!fire || out_free) begin
					pend_we = 1'b1; pend_wa = idx; pend_wd = pre_q[idx];
					done_n[idx]  = 1'b0;
					sched_n[idx] = fire;
					if (fire) begin
						em_v                 = 1'b1;
						em_res.kind          = 1'b1;
						em_res.dispatch_task = idx;
					end
					if (i_q == tc_q - CW'(1)) begin
						st_ok_n = 1'b1;
						state_n = S_STATUS;
					end else begin
						i_n = i_q + CW'(1);
					end
				end
			end

			S_DREQ: begin
				if (i_q < len_cur_q) begin
					dm_re   = 1'b1;
					dm_ra   = {cur_q.fin_id, idx};
					state_n = S_DUPD;
				end else begin
					state_n = S_DEND;
				end
			end

			// Release one dependent of the finished task
			S_DUPD: begin
				if (CW'(d) >= tc_q) begin
					i_n     = i_q + CW'(1);
					state_n = S_DREQ;
				end else begin
					np   = (pend_q[d] != '0) ? pend_q[d] - CW'(1) : '0;
					fire = (np == '0) && !sched_q[d];
					if (!fire || out_free) begin
						pend_we = 1'b1; pend_wa = d; pend_wd = np;
						if (fire) begin
							sched_n[d]           = 1'b1;
							em_v                 = 1'b1;
							em_res.kind          = 1'b1;
							em_res.dispatch_task = d;
						end
						i_n     = i_q + CW'(1);
						state_n = S_DREQ;
					end
				end
			end

			S_DEND: begin
				if (remaining_q == '0) begin
					running_n  = 1'b0;
					finished_n = 1'b1;
					st_gd_n    = 1'b1;
				end
				state_n = S_STATUS;
			end

			S_STATUS: begin
				if (out_free) begin
					em_v               = 1'b1;
					em_res.ok          = st_ok_q;
					em_res.assigned_id = st_id_q;
					em_res.graph_done  = st_gd_q;
					em_res.is_running  = running_q;
					em_res.is_finished = finished_q;
					em_res.done_total  = done_cnt_q;
					em_res.task_total  = tc_q;
					em_res.last        = 1'b1;
					state_n            = S_IDLE;
				end
			end

			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tc_q        <= '0;
			running_q   <= 1'b0;
			finished_q  <= 1'b0;
			remaining_q <= '0;
			done_cnt_q  <= '0;
			sched_q     <= '0;
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			tc_q        <= tc_n;
			running_q   <= running_n;
			finished_q  <= finished_n;
			remaining_q <= remaining_n;
			done_cnt_q  <= done_cnt_n;
			sched_q     <= sched_n;
			done_q      <= done_n;
			if (em_v) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Work registers and result payload
	always_ff @(posedge clk) begin
		cur_q     <= cur_n;
		i_q       <= i_n;
		head_q    <= head_n;
		tail_q    <= tail_n;
		visited_q <= visited_n;
		len_cur_q <= len_cur_n;
		sinks_q   <= sinks_n;
		wid_q     <= wid_n;
		st_ok_q   <= st_ok_n;
		st_gd_q   <= st_gd_n;
		st_id_q   <= st_id_n;
		if (em_v) begin
			res_q <= em_res;
		end
	end

	// Per-task tables
	always_ff @(posedge clk) begin
		if (len_we) begin
			len_q[len_wa] <= len_wd;
		end
		if (eb_we) begin
			eb_q[eb_wa] <= eb_wd;
		end
		if (pre_we) begin
			pre_q[pre_wa] <= pre_wd;
		end
		if (pend_we) begin
			pend_q[pend_wa] <= pend_wd;
		end
		if (scr_we) begin
			scr_q[scr_wa] <= scr_wd;
		end
		if (wq_we) begin
			wq_q[wq_wa] <= wq_wd;
		end
	end

	// Dependent list memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (dm_we) begin
			dep_mem[dm_wa] <= dm_wd;
		end
		if (dm_re) begin
			dm_rdata_q <= dep_mem[dm_ra];
		end
	end

endmodule

[sv/task_dependency_scheduler_unit.sv]
// Path: each request passes the front queue and then the back-end sequencer. Add task, add edge and
//   unknown requests go straight to the status item; task done reads each dependent; check scans
//   every task, walks the graph and reads every edge, and start adds a launch pass over the tasks.
// Throughput: one request at a time in the back-end sequencer, bounded by the registered reads of the
//   dependent-list memory; up to QUEUE_DEPTH requests (4 by default) wait in the front queue.
// Reset: arst_n clears the task count, run state, counters and scheduled/done flags.
module task_dependency_scheduler_unit #(
	parameter int QUEUE_DEPTH = tds_pkg::QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [tds_pkg::REQ_W-1:0] req_type,
	input  logic                      task_present,
	input  logic [tds_pkg::ID_W-1:0]  from_task,
	input  logic [tds_pkg::ID_W-1:0]  to_task,
	input  logic [tds_pkg::ID_W-1:0]  finished_task,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      kind,
	output logic [tds_pkg::ID_W-1:0]  dispatch_task,
	output logic                      ok,
	output logic [tds_pkg::ID_W-1:0]  assigned_id,
	output logic                      graph_done,
	output logic                      is_running,
	output logic                      is_finished,
	output logic [tds_pkg::CNT_W-1:0] done_total,
	output logic [tds_pkg::CNT_W-1:0] task_total,
	output logic                      last
);
	import tds_pkg::*;

	req_item_t q_item;
	logic      q_valid, q_pop;
	res_t      res;

	// Request intake and queue
	tds_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.task_present  (task_present),
		.from_task     (from_task),
		.to_task       (to_task),
		.finished_task (finished_task),
		.q_item        (q_item),
		.q_valid       (q_valid),
		.q_pop         (q_pop)
	);

	// Graph sequencer and result register
	tds_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_item    (q_item),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign kind          = res.kind;
	assign dispatch_task = res.dispatch_task;
	assign ok            = res.ok;
	assign assigned_id   = res.assigned_id;
	assign graph_done    = res.graph_done;
	assign is_running    = res.is_running;
	assign is_finished   = res.is_finished;
	assign done_total    = res.done_total;
	assign task_total    = res.task_total;
	assign last          = res.last;

`ifndef NO_ASSERTIONS
	// A status item never reports running and finished together
	a_run_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind |-> !(is_running && is_finished))
		else $error("status reports running and finished together");

	// A dispatch item is never the last item of a request and carries no ok or graph-done flag
	a_disp_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> !last && !ok && !graph_done)
		else $error("dispatch item carries status fields");

	// Finished count never exceeds the task count
	a_done_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind |-> done_total <= task_total)
		else $error("done total above task total");

	// Graph completion only ends a run
	a_gd_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind && graph_done |-> !is_running && is_finished)
		else $error("graph done while still running");
`endif

endmodule

[tb/task_dependency_scheduler_unit_tb.sv]
// Self-checking testbench for the task dependency scheduler: directed graphs, then random traffic.
module task_dependency_scheduler_unit_tb;
	import tds_pkg::*;

	// Predicted result item
	typedef struct packed {
		logic             kind;
		logic [ID_W-1:0]  dispatch_task;
		logic             ok;
		logic [ID_W-1:0]  assigned_id;
		logic             graph_done;
		logic             is_running;
		logic             is_finished;
		logic [CNT_W-1:0] done_total;
		logic [CNT_W-1:0] task_total;
		logic             last;
	} result_t;

	// Scheduler predictor plus queue of results still owed by the block
	class sched_scoreboard;
		int          n_tasks;
		int          dep_len [MAX_TASKS];
		int          dep_list [MAX_TASKS][MAX_TASKS];
		bit [MAX_TASKS-1:0] edges [MAX_TASKS];
		int          prereq [MAX_TASKS];
		int          pending [MAX_TASKS];
		bit          sched [MAX_TASKS];
		bit          fin_flag [MAX_TASKS];
		bit          running, finished;
		int          remaining, done_cnt;
		result_t     owed [$];
		int          errors;

		function void clear();
			n_tasks = 0; running = 0; finished = 0; remaining = 0; done_cnt = 0;
			for (int i = 0; i < MAX_TASKS; i++) begin
				sched[i] = 0; fin_flag[i] = 0;
			end
		endfunction

		function void push_dispatch(int id);
			result_t r;
			r = '0;
			r.kind = 1'b1;
			r.dispatch_task = ID_W'(id);
			owed.insert(owed.size(), r);
		endfunction

		function void push_status(int okv, int id, int gd);
			result_t r;
			r = '0;
			r.ok = 1'(okv);
			r.assigned_id = ID_W'(id);
			r.graph_done = 1'(gd);
			r.is_running = running;
			r.is_finished = finished;
			r.done_total = CNT_W'(done_cnt);
			r.task_total = CNT_W'(n_tasks);
			r.last = 1'b1;
			owed.insert(owed.size(), r);
		endfunction

		// One sink and a complete Kahn walk
		function bit graph_ok();
			int sinks, visited, head, tail, id, d;
			int indeg [MAX_TASKS];
			int q [MAX_TASKS];
			sinks = 0; visited = 0; head = 0; tail = 0;
			if (n_tasks == 0) return 0;
			for (int i = 0; i < n_tasks; i++) begin
				if (dep_len[i] == 0) sinks++;
				indeg[i] = prereq[i];
			end
			if (sinks != 1) return 0;
			for (int i = 0; i < n_tasks; i++)
				if (indeg[i] == 0) q[tail++] = i;
			while (head < tail) begin
				id = q[head++];
				visited++;
				for (int j = 0; j < dep_len[id]; j++) begin
					d = dep_list[id][j];
					if (indeg[d] == 0) continue;
					indeg[d]--;
					if (indeg[d] == 0 && tail < MAX_TASKS) q[tail++] = d;
				end
			end
			return visited == n_tasks;
		endfunction

		function void note_request(logic [REQ_W-1:0] rq, int pres, int fr, int to, int fn);
			int id, d;
			bit gd;
			case (rq)
				REQ_ADD: begin
					if (!pres || running || n_tasks >= MAX_TASKS) push_status(0, 0, 0);
					else begin
						id = n_tasks;
						dep_len[id] = 0; edges[id] = '0; prereq[id] = 0; pending[id] = 0;
						n_tasks++;
						push_status(1, id, 0);
					end
				end
				REQ_EDGE: begin
					if (running || fr >= n_tasks || to >= n_tasks || fr == to)
						push_status(0, 0, 0);
					else begin
						if (!edges[fr][to] && dep_len[fr] < MAX_TASKS) begin
							dep_list[fr][dep_len[fr]] = to;
							dep_len[fr]++;
							edges[fr][to] = 1'b1;
							prereq[to]++;
						end
						push_status(1, 0, 0);
					end
				end
				REQ_CHECK: push_status(graph_ok(), 0, 0);
				REQ_START: begin
					if (running || !graph_ok()) push_status(0, 0, 0);
					else begin
						running = 1; finished = 0; remaining = n_tasks; done_cnt = 0;
						for (int i = 0; i < n_tasks; i++) begin
							pending[i] = prereq[i];
							fin_flag[i] = 0;
							sched[i] = (pending[i] == 0);
							if (sched[i]) push_dispatch(i);
						end
						push_status(1, 0, 0);
					end
				end
				REQ_DONE: begin
					if (!running || fn >= n_tasks || fin_flag[fn]) push_status(0, 0, 0);
					else begin
						gd = 0;
						fin_flag[fn] = 1;
						done_cnt++;
						if (remaining > 0) remaining--;
						for (int j = 0; j < dep_len[fn]; j++) begin
							d = dep_list[fn][j];
							if (pending[d] > 0) pending[d]--;
							if (pending[d] == 0 && !sched[d]) begin
								sched[d] = 1;
								push_dispatch(d);
							end
						end
						if (remaining == 0) begin
							running = 0; finished = 1; gd = 1;
						end
						push_status(1, 0, gd);
					end
				end
				default: push_status(0, 0, 0);
			endcase
		endfunction

		function void check_result(result_t got);
			result_t exp_r;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result item %p", $time, got);
				errors++;
				return;
			end
			exp_r = owed.pop_front();
			if (got !== exp_r) begin
				$display("%0t: result mismatch expected %p actual %p", $time, exp_r, got);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [REQ_W-1:0] req_type;
	logic task_present;
	logic [ID_W-1:0] from_task, to_task, finished_task;
	logic kind, ok, graph_done, is_running, is_finished, last;
	logic [ID_W-1:0] dispatch_task, assigned_id;
	logic [CNT_W-1:0] done_total, task_total;

	sched_scoreboard sb;
	int send_idle_pct, recv_idle_pct;
	bit hold_off;

	task_dependency_scheduler_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .task_present(task_present),
		.from_task(from_task), .to_task(to_task), .finished_task(finished_task),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .dispatch_task(dispatch_task), .ok(ok), .assigned_id(assigned_id),
		.graph_done(graph_done), .is_running(is_running), .is_finished(is_finished),
		.done_total(done_total), .task_total(task_total), .last(last)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("status: fail");
		$finish;
	end

	// Offer one request; note it in the predictor when accepted
	task send_req(logic [REQ_W-1:0] rq, int pres, int fr, int to, int fn);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		req_type <= rq; task_present <= 1'(pres);
		from_task <= ID_W'(fr); to_task <= ID_W'(to); finished_task <= ID_W'(fn);
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		sb.note_request(rq, pres, fr, to, fn);
		@(negedge clk);
	endtask

	// Random graph with a single sink: chain-like edges toward the highest id
	task build_graph(int n);
		for (int i = 0; i < n; i++) send_req(REQ_ADD, 1, 0, 0, 0);
		for (int i = 0; i < n - 1; i++) begin
			send_req(REQ_EDGE, 0, i, $urandom_range(n - 1, i + 1), 0);
			if ($urandom_range(1)) send_req(REQ_EDGE, 0, i, $urandom_range(n - 1, i + 1), 0);
		end
	endtask

	// Run the graph: report done for every task in shuffled order, with occasional random done requests
	task run_graph(int n);
		int order [$];
		send_req(REQ_START, 0, 0, 0, 0);
		for (int i = 0; i < n; i++) order.insert(order.size(), i);
		order.shuffle();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) send_req(REQ_DONE, 0, 0, 0, $urandom_range(15));
			send_req(REQ_DONE, 0, 0, 0, order[i]);
		end
	endtask

	// Stop offering and wait until every owed result has come out
	task wait_drained();
		in_valid <= 0;
		while (sb.owed.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task noise(int count);
		for (int i = 0; i < count; i++)
			send_req(REQ_W'($urandom_range(7)), $urandom_range(1), $urandom_range(15),
				$urandom_range(15), $urandom_range(15));
	endtask

	// Receiver with random stalls and one long hold-off
	always @(negedge clk) begin
		if (!arst_n || hold_off) out_ready <= 0;
		else out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({kind, dispatch_task, ok, assigned_id, graph_done, is_running,
				is_finished, done_total, task_total, last});
	end

	initial begin
		sb = new();
		sb.clear();
		sb.errors = 0;
		send_idle_pct = 0; recv_idle_pct = 0; hold_off = 0;
		in_valid = 0; req_type = REQ_ADD; task_present = 0;
		from_task = 0; to_task = 0; finished_task = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: empty graph, null task, unknown codes, bad edges, rejected run requests
		send_req(REQ_CHECK, 0, 0, 0, 0);
		send_req(REQ_START, 0, 0, 0, 0);
		send_req(REQ_DONE, 0, 0, 0, 0);
		send_req(REQ_ADD, 0, 0, 0, 0);
		send_req(3'd5, 1, 15, 15, 15);
		send_req(3'd7, 0, 0, 0, 0);
		send_req(REQ_ADD, 1, 0, 0, 0);
		send_req(REQ_ADD, 1, 0, 0, 0);
		send_req(REQ_EDGE, 0, 1, 1, 0);
		send_req(REQ_EDGE, 0, 0, 15, 0);
		send_req(REQ_CHECK, 0, 0, 0, 0);
		send_req(REQ_EDGE, 0, 0, 1, 0);
		send_req(REQ_EDGE, 0, 0, 1, 0);
		// Two-task run: root dispatch, repeated done, release of the sink
		send_req(REQ_START, 0, 0, 0, 0);
		send_req(REQ_DONE, 0, 0, 0, 0);
		send_req(REQ_DONE, 0, 0, 0, 0);
		send_req(REQ_DONE, 0, 0, 0, 1);
		send_req(REQ_EDGE, 0, 1, 0, 0);
		send_req(REQ_CHECK, 0, 0, 0, 0);
		send_req(REQ_START, 0, 0, 0, 0);
		// Fill table while a cycle exists, then break nothing: still invalid
		for (int i = 2; i < MAX_TASKS; i++) send_req(REQ_ADD, 1, 0, 0, 0);
		send_req(REQ_ADD, 1, 0, 0, 0);
		send_req(REQ_EDGE, 0, 15, 14, 0);
		wait_drained();

		// Random phases on the full table: edges, checks and noise
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 58 : 0;
			recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 19 : 0;
			for (int k = 0; k < 55; k++) begin
				send_req(REQ_EDGE, 0, $urandom_range(15), $urandom_range(15), 0);
				send_req(REQ_CHECK, $urandom_range(1), 0, 0, 0);
				noise(1);
			end
			if (ph == 1) begin
				// Long receiver hold-off while requests keep coming
				fork
					begin
						hold_off = 1;
						repeat (400) @(negedge clk);
						hold_off = 0;
					end
					noise(20);
				join
			end
			wait_drained();
		end
		repeat (50) @(negedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule

[sim.f]
sv/tds_pkg.sv
sv/tds_front.sv
sv/tds_back.sv
sv/task_dependency_scheduler_unit.sv
tb/task_dependency_scheduler_unit_tb.sv
